/* rtl/core/bics_pkg.sv */
// shared constants and state types for the bump interval capacity sampler
package bics_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NET_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPACING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUMP_SIZE   = 2'd2;

  localparam logic [CFG_W-1:0] NET_WIDTH_RST   = 16'd256;
  localparam logic [CFG_W-1:0] MIN_SPACING_RST = 16'd256;
  localparam logic [CFG_W-1:0] BUMP_SIZE_RST   = 16'd1024;

  // interval kinds
  localparam logic [1:0] KIND_PAIR = 2'd0;
  localparam logic [1:0] KIND_HEAD = 2'd1;
  localparam logic [1:0] KIND_TAIL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENDS,
    ST_GAP,
    ST_LAUNCH,
    ST_DIV,
    ST_EMIT
  } bics_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_FIX
  } bics_div_state_t;

endpackage

/* rtl/core/bics_div.sv */
// bit-serial signed floor divider: one quotient bit per cycle, then a sign fix-up
module bics_div #(
  parameter int DW = 38,
  parameter int VW = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic        [VW-1:0] divisor,
  output logic                 busy,
  output logic signed [DW-1:0] quotient,
  output logic        [VW-1:0] remainder
);

  localparam int CNTW = (DW > 1) ? $clog2(DW) : 1;

  bics_pkg::bics_div_state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]   mq_r;
  logic [VW-1:0]   rem_r;
  logic [VW-1:0]   dvs_r;
  logic            neg_r;

  logic [VW:0]     trial;
  logic [VW:0]     diff;
  logic            ge;
  logic [DW-1:0]   mag;

  // partial remainder takes the next dividend bit from the top of the shift register
  assign trial = {rem_r, mq_r[DW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign mag   = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      bics_pkg::DV_IDLE: begin
        if (start) begin
          state_nxt = bics_pkg::DV_RUN;
          cnt_nxt   = CNTW'(DW - 1);
        end
      end
      bics_pkg::DV_RUN: begin
        if (cnt_r == '0) begin
          state_nxt = bics_pkg::DV_FIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      bics_pkg::DV_FIX: begin
        state_nxt = bics_pkg::DV_IDLE;
      end
      default: begin
        state_nxt = bics_pkg::DV_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = (state_r != bics_pkg::DV_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bics_pkg::DV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      bics_pkg::DV_IDLE: begin
        if (start) begin
          mq_r  <= mag;
          rem_r <= '0;
          dvs_r <= divisor;
          neg_r <= dividend[DW-1];
        end
      end
      bics_pkg::DV_RUN: begin
        mq_r  <= {mq_r[DW-2:0], ge};
        rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
      end
      bics_pkg::DV_FIX: begin
        // negative dividend: round the quotient toward minus infinity
        if (neg_r) begin
          if (rem_r != '0) begin
            mq_r  <= ~mq_r;
            rem_r <= dvs_r - rem_r;
          end else begin
            mq_r <= DW'(-mq_r);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign quotient  = signed'(mq_r);
  assign remainder = rem_r;

endmodule

/* rtl/core/bump_interval_capacity_sampler.sv */
// top level: bump interval capacity and evenly spaced sample points
//
// usage: an interval request is taken on the in_ ports at a clock edge where
// start is high and busy is low. a request is either a bump pair or a single
// bump with a head or tail boundary; coordinates are signed q24.8 held in the
// low COORD_WIDTH bits (16 to 32 used). each result beat is shown for exactly
// one cycle with out_valid high: capacity, point x/y and a last_point flag.
// one request gives 1, 4, 8 or 16 beats, one per cycle, the final one flagged.
// sequence: the request is captured, the set-up states ENDS and GAP follow,
// then a launch state, bit-serial division with a sign fix step, and a
// state that sees the dividers finish, then the result beats. the serial
// dividers set the length of a request. busy stays high throughout and a
// new request is taken the cycle after the last beat. the receiver cannot
// stall the beats. configuration is written with cfg_we, cfg_index and
// cfg_wdata; the user must write it only while busy is low, as the block
// does not enforce this. synchronous reset returns the sequencer to idle and
// the configuration registers to their reset values.
module bump_interval_capacity_sampler #(
  parameter int COORD_WIDTH = 32,
  parameter int MAX_SAMPLES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_kind,
  input  logic                                   in_horizontal_span,
  input  logic signed [31:0]                     in_first_bump_x,
  input  logic signed [31:0]                     in_first_bump_y,
  input  logic signed [31:0]                     in_second_bump_x,
  input  logic signed [31:0]                     in_second_bump_y,
  input  logic signed [31:0]                     in_boundary_y,
  output logic                                   out_valid,
  output logic [31:0]                            out_capacity,
  output logic signed [31:0]                     out_point_x,
  output logic signed [31:0]                     out_point_y,
  output logic                                   out_last_point,
  input  logic                                   cfg_we,
  input  logic [bics_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bics_pkg::CFG_W-1:0]             cfg_wdata
);

  localparam int CW = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
  // half-unit working width: coordinate doubled plus offsets of up to 19 bits
  localparam int W  = CW + 6;
  localparam int KW = $clog2(MAX_SAMPLES);
  localparam int PW = bics_pkg::CFG_W + 1;
  localparam logic signed [W-1:0] ONE_W  = 1;
  localparam logic signed [W-1:0] ZERO_W = 0;

  bics_pkg::bics_state_t state_r, state_nxt;

  logic [bics_pkg::CFG_W-1:0] nw_r, ms_r, bs_r;

  logic [1:0]          kind_r;
  logic                horiz_r;
  logic signed [W-1:0] x1_r, y1_r, x2_r, y2_r, by_r;
  logic signed [W-1:0] fx2_r, lx2_r, fy2_r, ly2_r, num_r, mx_r, my_r;
  logic signed [W-1:0] dx_r, dy_r, qx_r, qy_r;
  logic [KW:0]         rx_r, ry_r;
  logic [KW-1:0]       m_r, k_r;
  logic                fallback_r;
  logic [31:0]         cap_r;

  logic                div_start;
  logic                capdiv_busy, xdiv_busy, ydiv_busy;
  logic signed [W-1:0] cap_quo, qdx, qdy;
  logic [KW:0]         rdx, rdy;

  logic                endpoint;
  logic signed [W-1:0] nw_w, ms_w, bs_w, p_w;
  logic signed [W-1:0] ext_w;
  logic signed [W-1:0] gap2, p6, p14, p30;
  logic                fallback_nxt;
  logic [KW-1:0]       m_nxt;
  logic [PW-1:0]       pitch;
  logic [KW:0]         two_m;
  logic [KW+1:0]       sumx, sumy, subx, suby;
  logic                carx, cary;
  logic [63:0]         cap64;
  logic [31:0]         cap_nxt;

  function automatic logic [31:0] sat_coord(input logic signed [W-1:0] v);
    logic signed [W-1:0]  hi;
    logic signed [W-1:0]  lo;
    logic signed [CW-1:0] s;
    hi = W'(signed'({1'b0, {(CW-1){1'b1}}}));
    lo = W'(signed'({1'b1, {(CW-1){1'b0}}}));
    if (v > hi) begin
      s = hi[CW-1:0];
    end else if (v < lo) begin
      s = lo[CW-1:0];
    end else begin
      s = v[CW-1:0];
    end
    return 32'(s);
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nw_r <= bics_pkg::NET_WIDTH_RST;
      ms_r <= bics_pkg::MIN_SPACING_RST;
      bs_r <= bics_pkg::BUMP_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bics_pkg::CFG_NET_WIDTH:   nw_r <= cfg_wdata;
        bics_pkg::CFG_MIN_SPACING: ms_r <= cfg_wdata;
        bics_pkg::CFG_BUMP_SIZE:   bs_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign endpoint = (kind_r == bics_pkg::KIND_HEAD) || (kind_r == bics_pkg::KIND_TAIL);
  assign nw_w  = signed'(W'(nw_r));
  assign ms_w  = signed'(W'(ms_r));
  assign bs_w  = signed'(W'(bs_r));
  assign pitch = PW'(nw_r) + PW'(ms_r);
  assign p_w   = signed'(W'(pitch));
  // offset from bump centre to first wire centre, in half units
  assign ext_w = endpoint ? ((bs_w <<< 1) + (ms_w <<< 1) + nw_w) : (bs_w + (ms_w <<< 1) + nw_w);

  assign gap2 = fy2_r - ly2_r;
  assign p6   = (p_w <<< 2) + (p_w <<< 1);
  assign p14  = (p_w <<< 4) - (p_w <<< 1);
  assign p30  = (p_w <<< 5) - (p_w <<< 1);

  always_comb begin
    fallback_nxt = (gap2 < p6);
    if ((MAX_SAMPLES >= 16) && (gap2 >= p30)) begin
      m_nxt = KW'(15);
    end else if ((MAX_SAMPLES >= 8) && (gap2 >= p14)) begin
      m_nxt = KW'(7);
    end else begin
      m_nxt = KW'(3);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bics_pkg::ST_IDLE: begin
        if (start) state_nxt = bics_pkg::ST_ENDS;
      end
      bics_pkg::ST_ENDS:   state_nxt = bics_pkg::ST_GAP;
      bics_pkg::ST_GAP:    state_nxt = bics_pkg::ST_LAUNCH;
      bics_pkg::ST_LAUNCH: state_nxt = bics_pkg::ST_DIV;
      bics_pkg::ST_DIV: begin
        if (!(capdiv_busy || xdiv_busy || ydiv_busy)) state_nxt = bics_pkg::ST_EMIT;
      end
      bics_pkg::ST_EMIT: begin
        if (out_last_point) state_nxt = bics_pkg::ST_IDLE;
      end
      default: state_nxt = bics_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy      = (state_r != bics_pkg::ST_IDLE);
    div_start = (state_r == bics_pkg::ST_LAUNCH);
    out_valid = (state_r == bics_pkg::ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bics_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  bics_div #(.DW(W), .VW(PW)) u_capdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (num_r),
    .divisor   (pitch),
    .busy      (capdiv_busy),
    .quotient  (cap_quo),
    .remainder ()
  );

  bics_div #(.DW(W), .VW(KW + 1)) u_xdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dx_r),
    .divisor   ({m_r, 1'b0}),
    .busy      (xdiv_busy),
    .quotient  (qdx),
    .remainder (rdx)
  );

  bics_div #(.DW(W), .VW(KW + 1)) u_ydiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dy_r),
    .divisor   ({m_r, 1'b0}),
    .busy      (ydiv_busy),
    .quotient  (qdy),
    .remainder (rdy)
  );

  assign cap64 = 64'(cap_quo);

  always_comb begin
    if (endpoint) begin
      cap_nxt = '1;
    end else if (num_r <= ZERO_W) begin
      cap_nxt = '0;
    end else if (pitch == '0) begin
      cap_nxt = '1;
    end else if (|cap64[63:32]) begin
      cap_nxt = '1;
    end else begin
      cap_nxt = cap64[31:0];
    end
  end

  // point stepping: quotient and remainder of the step by 2m, carry on overflow
  assign two_m = {m_r, 1'b0};
  assign sumx  = {1'b0, rx_r} + {1'b0, rdx};
  assign sumy  = {1'b0, ry_r} + {1'b0, rdy};
  assign subx  = sumx - {1'b0, two_m};
  assign suby  = sumy - {1'b0, two_m};
  assign carx  = (sumx >= {1'b0, two_m});
  assign cary  = (sumy >= {1'b0, two_m});

  always_ff @(posedge clk) begin
    case (state_r)
      bics_pkg::ST_IDLE: begin
        if (start) begin
          kind_r  <= in_kind;
          horiz_r <= in_horizontal_span;
          x1_r    <= W'(signed'(in_first_bump_x[CW-1:0]));
          y1_r    <= W'(signed'(in_first_bump_y[CW-1:0]));
          x2_r    <= W'(signed'(in_second_bump_x[CW-1:0]));
          y2_r    <= W'(signed'(in_second_bump_y[CW-1:0]));
          by_r    <= W'(signed'(in_boundary_y[CW-1:0]));
        end
      end
      bics_pkg::ST_ENDS: begin
        fx2_r <= x1_r <<< 1;
        lx2_r <= endpoint ? (x1_r <<< 1) : (x2_r <<< 1);
        if (kind_r == bics_pkg::KIND_HEAD) begin
          fy2_r <= by_r <<< 1;
          ly2_r <= (y1_r <<< 1) + ext_w;
        end else if (kind_r == bics_pkg::KIND_TAIL) begin
          fy2_r <= (y1_r <<< 1) - ext_w;
          ly2_r <= by_r <<< 1;
        end else begin
          fy2_r <= (y1_r <<< 1) - ext_w;
          ly2_r <= (y2_r <<< 1) + ext_w;
        end
        num_r <= (horiz_r ? (y1_r - y2_r) : (x1_r - x2_r)) - bs_w - ms_w;
        mx_r  <= (x1_r + x2_r + ONE_W) >>> 1;
        my_r  <= (y1_r + y2_r + ONE_W) >>> 1;
      end
      bics_pkg::ST_GAP: begin
        fallback_r <= fallback_nxt;
        m_r        <= m_nxt;
        k_r        <= '0;
        dx_r       <= lx2_r - fx2_r;
        dy_r       <= ly2_r - fy2_r;
        // remainder of (end + 1) * m over 2m: m when the end is even, else none
        rx_r       <= fx2_r[0] ? '0 : {1'b0, m_nxt};
        ry_r       <= fy2_r[0] ? '0 : {1'b0, m_nxt};
        if (fallback_nxt && !endpoint) begin
          qx_r <= mx_r;
          qy_r <= my_r;
        end else if (fallback_nxt && (kind_r == bics_pkg::KIND_HEAD)) begin
          qx_r <= (fx2_r + ONE_W) >>> 1;
          qy_r <= (ly2_r + ONE_W) >>> 1;
        end else begin
          qx_r <= (fx2_r + ONE_W) >>> 1;
          qy_r <= (fy2_r + ONE_W) >>> 1;
        end
      end
      bics_pkg::ST_DIV: begin
        cap_r <= cap_nxt;
      end
      bics_pkg::ST_EMIT: begin
        k_r  <= k_r + 1'b1;
        qx_r <= qx_r + qdx + (carx ? ONE_W : ZERO_W);
        qy_r <= qy_r + qdy + (cary ? ONE_W : ZERO_W);
        rx_r <= carx ? subx[KW:0] : sumx[KW:0];
        ry_r <= cary ? suby[KW:0] : sumy[KW:0];
      end
      default: begin
      end
    endcase
  end

  assign out_capacity   = cap_r;
  assign out_point_x    = signed'(sat_coord(qx_r));
  assign out_point_y    = signed'(sat_coord(qy_r));
  assign out_last_point = fallback_r || (k_r == m_r);

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_point |=> !out_valid)
    else $error("beat after the last point of an interval");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bics_pkg::ST_EMIT) |-> (k_r <= m_r))
    else $error("sample index ran past the point count");

  a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bics_pkg::ST_EMIT) |-> ((rx_r < two_m) && (ry_r < two_m)))
    else $error("step remainder not below twice the interval count");

  a_endpoint_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && endpoint |-> (out_capacity == 32'hFFFF_FFFF))
    else $error("endpoint interval without full capacity");

  a_div_done_before_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(capdiv_busy || xdiv_busy || ydiv_busy))
    else $error("beat shown while a divider is still running");

endmodule
